// ----- design/xmltok_pkg.sv -----
// Shared codes, types and character classes for the XML markup tokenizer.
package xmltok_pkg;

  localparam logic [2:0] RoleSpace = 3'd0;
  localparam logic [2:0] RoleTag   = 3'd1;
  localparam logic [2:0] RoleAName = 3'd2;
  localparam logic [2:0] RoleAVal  = 3'd3;
  localparam logic [2:0] RoleText  = 3'd4;
  localparam logic [2:0] RoleCmt   = 3'd5;
  localparam logic [2:0] RolePunct = 3'd6;

  localparam logic [1:0] EvNone  = 2'd0;
  localparam logic [1:0] EvStart = 2'd1;
  localparam logic [1:0] EvEmpty = 2'd2;
  localparam logic [1:0] EvEnd   = 2'd3;

  localparam logic [2:0] ErrOk       = 3'd0;
  localparam logic [2:0] ErrSyntax   = 3'd1;
  localparam logic [2:0] ErrUnmatch  = 3'd2;
  localparam logic [2:0] ErrDeep     = 3'd3;
  localparam logic [2:0] ErrNameLen  = 3'd4;
  localparam logic [2:0] ErrAttrs    = 3'd5;
  localparam logic [2:0] ErrTrunc    = 3'd6;

  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChQuest = 8'h3F;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChDquot = 8'h22;
  localparam logic [7:0] ChSquot = 8'h27;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] role;
    logic [1:0] event_res;
    logic [2:0] attr_slot;
    logic [4:0] nest_depth;
    logic [2:0] error_code;
  } tok_word_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_name(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || c == ChUnder || c == ChDot;
  endfunction

endpackage

// ----- design/xml_markup_tokenizer.sv -----
// XML markup tokenizer: per-byte role, tag events, nesting depth and sticky error.
// One byte is taken per clock unless a stalled output word holds the input; each
// word leaves through an output register, so the sustained rate without stalls is
// one byte per cycle. Open tag names sit in a synchronous name memory of
// MAX_DEPTH*MAX_NAME_LEN bytes; the read address for the next byte is issued from
// the next parser state every cycle, so each end-tag character is compared against
// a stacked character already fetched. Errors stick until reset; after an error
// every word carries role, event and slot zero. Name memory entries are defined
// only once written; only written entries take part in a comparison.
module xml_markup_tokenizer
  import xmltok_pkg::*;
#(
  parameter int MAX_DEPTH    = 16,
  parameter int MAX_NAME_LEN = 32,
  parameter int MAX_ATTRS    = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_in_i,
  input  logic       doc_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] byte_out_o,
  output logic [2:0] role_o,
  output logic [1:0] event_res_o,
  output logic [2:0] attr_slot_o,
  output logic [4:0] nest_depth_o,
  output logic [2:0] error_code_o
);

  localparam int DW  = $clog2(MAX_DEPTH + 1);
  localparam int TW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CW  = $clog2(MAX_NAME_LEN + 1);
  localparam int NW  = $clog2(MAX_ATTRS + 1);
  localparam int MD  = MAX_DEPTH * MAX_NAME_LEN;
  localparam int AW  = $clog2(MD);

  typedef enum logic [4:0] {
    MOut, MLt, MCmtD1, MCmtD2, MCmt, MCmtE1, MCmtE2, MPi, MPiQ, MTagPre,
    MName, MAttrWait, MAName, MAEq, MAvq, MAval, MEmptyGt, MEndWs, MErr
  } mode_e;

  mode_e           mode_q, mode_d;
  logic [DW-1:0]   depth_q, depth_d;
  logic [CW-1:0]   cidx_q, cidx_d;
  logic [NW-1:0]   attr_q, attr_d;
  logic [7:0]      quote_q, quote_d;
  logic            close_q, close_d;
  logic [2:0]      err_q, err_d;
  logic            ovalid_q;
  tok_word_t       oword_q, oword_d;

  logic [7:0]      mem_q [MD];
  logic [7:0]      rd_q;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic            wr_en;
  logic [CW-1:0]   len_q [MAX_DEPTH];
  logic            len_we;
  logic [TW-1:0]   top;
  logic [TW-1:0]   top_d;
  logic [CW-1:0]   top_len;

  logic            accept;
  logic [7:0]      b;
  logic            sp, nm;
  logic [2:0]      role, slot, fcode;
  logic [1:0]      ev;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = ovalid_q && out_stall_i;
  assign b          = byte_in_i;
  assign sp         = is_space(b);
  assign nm         = is_name(b);
  assign top        = TW'(depth_q - DW'(1));
  assign top_len    = len_q[top];
  assign wr_addr    = AW'(depth_q[TW-1:0]) * AW'(MAX_NAME_LEN) + AW'(cidx_q);
  assign top_d      = TW'(depth_d - DW'(1));
  assign rd_addr    = (depth_d != '0 && cidx_d < CW'(MAX_NAME_LEN)) ?
                      AW'(top_d) * AW'(MAX_NAME_LEN) + AW'(cidx_d) : '0;

  always_comb begin
    mode_d  = mode_q;
    depth_d = depth_q;
    cidx_d  = cidx_q;
    attr_d  = attr_q;
    quote_d = quote_q;
    close_d = close_q;
    err_d   = err_q;
    role    = RoleSpace;
    slot    = 3'd0;
    ev      = EvNone;
    fcode   = ErrOk;
    wr_en   = 1'b0;
    len_we  = 1'b0;
    if (err_q == ErrOk) begin
      unique case (mode_q)
        MOut: begin
          if (b == ChLt) begin
            role = RolePunct; mode_d = MLt;
            cidx_d = '0; attr_d = '0; close_d = 1'b0;
          end else if (sp) role = RoleSpace;
          else if (depth_q != '0) role = RoleText;
          else fcode = ErrSyntax;
        end
        MLt, MTagPre, MName: begin
          if (mode_q == MLt && b == ChBang) begin
            role = RolePunct; mode_d = MCmtD1;
          end else if (mode_q == MLt && b == ChQuest) begin
            role = RolePunct; mode_d = MPi;
          end else if (mode_q == MLt && b == ChSlash) begin
            role = RolePunct; close_d = 1'b1; mode_d = MTagPre;
          end else if (nm) begin
            role = RoleTag; mode_d = MName;
            // compare against the stacked name, or push the next character
            if (close_q) begin
              if (depth_q == '0 || cidx_q >= top_len ||
                  cidx_q >= CW'(MAX_NAME_LEN) || rd_q != b) fcode = ErrUnmatch;
              else cidx_d = cidx_q + CW'(1);
            end else begin
              if (cidx_q >= CW'(MAX_NAME_LEN)) fcode = ErrNameLen;
              else begin
                wr_en  = depth_q < DW'(MAX_DEPTH);
                cidx_d = cidx_q + CW'(1);
              end
            end
          end else if (sp && mode_q != MName) begin
            role = RoleSpace; mode_d = MTagPre;
          end else if (mode_q != MName) fcode = ErrSyntax;
          else if (sp) begin
            role = RoleSpace; len_we = !close_q && depth_q < DW'(MAX_DEPTH);
            mode_d = close_q ? MEndWs : MAttrWait;
          end else if (b == ChGt) begin
            role = RolePunct; len_we = !close_q && depth_q < DW'(MAX_DEPTH);
            if (close_q) begin
              if (depth_q == '0 || cidx_q != top_len) fcode = ErrUnmatch;
              else begin
                depth_d = depth_q - DW'(1); close_d = 1'b0; ev = EvEnd; mode_d = MOut;
              end
            end else begin
              if (depth_q >= DW'(MAX_DEPTH)) fcode = ErrDeep;
              else begin
                depth_d = depth_q + DW'(1); ev = EvStart; mode_d = MOut;
              end
            end
          end else if (b == ChSlash && !close_q) begin
            role = RolePunct; len_we = depth_q < DW'(MAX_DEPTH); mode_d = MEmptyGt;
          end else fcode = ErrSyntax;
        end
        MCmtD1: begin
          if (b == ChDash) begin role = RolePunct; mode_d = MCmtD2; end
          else fcode = ErrSyntax;
        end
        MCmtD2: begin
          if (b == ChDash) begin role = RolePunct; mode_d = MCmt; end
          else fcode = ErrSyntax;
        end
        MCmt: begin
          role = RoleCmt;
          if (b == ChDash) mode_d = MCmtE1;
        end
        MCmtE1: begin
          role = RoleCmt;
          mode_d = (b == ChDash) ? MCmtE2 : MCmt;
        end
        MCmtE2: begin
          if (b == ChGt) begin role = RolePunct; mode_d = MOut; end
          else begin
            role = RoleCmt;
            if (b != ChDash) mode_d = MCmt;
          end
        end
        MPi: begin
          if (b == ChQuest) begin role = RolePunct; mode_d = MPiQ; end
          else role = RoleCmt;
        end
        MPiQ: begin
          if (b == ChGt) begin role = RolePunct; mode_d = MOut; end
          else fcode = ErrSyntax;
        end
        MEndWs: begin
          if (sp) role = RoleSpace;
          else if (b == ChGt) begin
            role = RolePunct;
            if (depth_q == '0 || cidx_q != top_len) fcode = ErrUnmatch;
            else begin
              depth_d = depth_q - DW'(1); close_d = 1'b0; ev = EvEnd; mode_d = MOut;
            end
          end else fcode = ErrSyntax;
        end
        MAttrWait: begin
          if (sp) role = RoleSpace;
          else if (b == ChGt) begin
            role = RolePunct;
            if (depth_q >= DW'(MAX_DEPTH)) fcode = ErrDeep;
            else begin
              depth_d = depth_q + DW'(1); ev = EvStart; mode_d = MOut;
            end
          end else if (b == ChSlash) begin
            role = RolePunct; mode_d = MEmptyGt;
          end else if (nm) begin
            if (attr_q >= NW'(MAX_ATTRS)) fcode = ErrAttrs;
            else begin
              role = RoleAName; slot = 3'(attr_q);
              cidx_d = CW'(1); mode_d = MAName;
            end
          end else fcode = ErrSyntax;
        end
        MAName: begin
          slot = 3'(attr_q);
          if (nm) begin
            if (cidx_q >= CW'(MAX_NAME_LEN)) fcode = ErrNameLen;
            else begin role = RoleAName; cidx_d = cidx_q + CW'(1); end
          end else if (sp) begin role = RoleSpace; mode_d = MAEq; end
          else if (b == ChEq) begin role = RolePunct; mode_d = MAvq; end
          else fcode = ErrSyntax;
        end
        MAEq: begin
          slot = 3'(attr_q);
          if (sp) role = RoleSpace;
          else if (b == ChEq) begin role = RolePunct; mode_d = MAvq; end
          else fcode = ErrSyntax;
        end
        MAvq: begin
          slot = 3'(attr_q);
          if (sp) role = RoleSpace;
          else if (b == ChDquot || b == ChSquot) begin
            role = RolePunct; quote_d = b; mode_d = MAval;
          end else fcode = ErrSyntax;
        end
        MAval: begin
          slot = 3'(attr_q);
          if (b == quote_q) begin
            role = RolePunct; attr_d = attr_q + NW'(1); mode_d = MAttrWait;
          end else role = RoleAVal;
        end
        MEmptyGt: begin
          if (b == ChGt) begin role = RolePunct; ev = EvEmpty; mode_d = MOut; end
          else fcode = ErrSyntax;
        end
        default: fcode = ErrSyntax;
      endcase
      if (fcode != ErrOk) begin
        err_d = fcode; mode_d = MErr;
        role = RoleSpace; slot = 3'd0; ev = EvNone;
        wr_en = 1'b0;
      end
      // unfinished markup or open elements at document end
      if (fcode == ErrOk && doc_end_i && (mode_d != MOut || depth_d != '0)) begin
        err_d = ErrTrunc; mode_d = MErr;
      end
    end
    if (!accept) begin
      mode_d = mode_q; depth_d = depth_q; cidx_d = cidx_q; attr_d = attr_q;
      quote_d = quote_q; close_d = close_q; err_d = err_q;
      wr_en = 1'b0; len_we = 1'b0;
    end
    oword_d.byte_out   = b;
    oword_d.role       = role;
    oword_d.event_res  = ev;
    oword_d.attr_slot  = slot;
    oword_d.nest_depth = 5'(depth_d);
    oword_d.error_code = err_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= b;
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (len_we) len_q[depth_q[TW-1:0]] <= cidx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MOut;
      depth_q  <= '0;
      cidx_q   <= '0;
      attr_q   <= '0;
      quote_q  <= '0;
      close_q  <= 1'b0;
      err_q    <= ErrOk;
      ovalid_q <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      depth_q <= depth_d;
      cidx_q  <= cidx_d;
      attr_q  <= attr_d;
      quote_q <= quote_d;
      close_q <= close_d;
      err_q   <= err_d;
      if (accept) ovalid_q <= 1'b1;
      else if (!out_stall_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) oword_q <= oword_d;
  end

  assign out_valid_o  = ovalid_q;
  assign byte_out_o   = oword_q.byte_out;
  assign role_o       = oword_q.role;
  assign event_res_o  = oword_q.event_res;
  assign attr_slot_o  = oword_q.attr_slot;
  assign nest_depth_o = oword_q.nest_depth;
  assign error_code_o = oword_q.error_code;

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q != ErrOk |=> err_q == $past(err_q))
    else $error("sticky error changed");

  a_depth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(MAX_DEPTH))
    else $error("open depth beyond limit");

  a_err_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ErrOk) == (mode_q == MErr))
    else $error("error state and mode disagree");

  a_event_punct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && oword_q.event_res != EvNone |-> oword_q.role == RolePunct)
    else $error("tag event on a non-punctuation byte");

endmodule

// ----- test/tb_top.sv -----
// Testbench for the XML markup tokenizer: byte stream in, predicted words checked out.
`timescale 1ns / 1ps

module tb_top;
  import xmltok_pkg::*;

  localparam int DEPTH_MAX = 16;
  localparam int NAME_MAX  = 32;
  localparam int ATTRS_MAX = 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [4:0] {
    PmOut, PmLt, PmCmtD1, PmCmtD2, PmCmt, PmCmtE1, PmCmtE2, PmPi, PmPiQ,
    PmTagPre, PmName, PmAttrWait, PmAName, PmAEq, PmAvq, PmAval, PmEmptyGt,
    PmEndWs, PmErr
  } pmode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [7:0] byte_in_i = 8'h00;
  logic doc_end_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] byte_out_o;
  logic [2:0] role_o;
  logic [1:0] event_res_o;
  logic [2:0] attr_slot_o;
  logic [4:0] nest_depth_o;
  logic [2:0] error_code_o;

  always #5 clk_i = ~clk_i;

  xml_markup_tokenizer u_dut (.*);

  // tokenizer shadow state
  pmode_e     pm;
  logic [7:0] names [DEPTH_MAX*NAME_MAX];
  int         name_len [DEPTH_MAX];
  int         depth, cidx, acount, closing;
  logic [7:0] quote;
  logic [2:0] err;
  logic [1:0] ev;

  logic [8:0] byte_queue [$];   // {doc_end, byte}
  tok_word_t  expected_words [$];
  int mismatches = 0;
  int cycles = 0;
  bit hold_off = 1'b0;
  bit in_taken = 1'b0;

  function automatic bit sp(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit nmc(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == ChUnder || c == ChDot;
  endfunction

  task automatic raise(logic [2:0] code);
    if (err == ErrOk) err = code;
    pm = PmErr;
  endtask

  task automatic name_char(logic [7:0] b);
    if (closing) begin
      if (depth == 0 || cidx >= name_len[depth-1] || cidx >= NAME_MAX ||
          names[(depth-1)*NAME_MAX + cidx] != b) begin
        raise(ErrUnmatch);
        return;
      end
      cidx++;
    end else begin
      if (cidx >= NAME_MAX) begin
        raise(ErrNameLen);
        return;
      end
      if (depth < DEPTH_MAX) names[depth*NAME_MAX + cidx] = b;
      cidx++;
    end
  endtask

  task automatic close_name();
    if (!closing && depth < DEPTH_MAX) name_len[depth] = cidx;
  endtask

  task automatic open_elem();
    if (depth >= DEPTH_MAX) begin
      raise(ErrDeep);
      return;
    end
    depth++;
    ev = EvStart;
    pm = PmOut;
  endtask

  task automatic close_elem();
    if (depth == 0 || cidx != name_len[depth-1]) begin
      raise(ErrUnmatch);
      return;
    end
    depth--;
    closing = 0;
    ev = EvEnd;
    pm = PmOut;
  endtask

  task automatic tokenize(input logic [7:0] b, input logic fin, output tok_word_t w);
    logic [2:0] role;
    logic [2:0] slot;
    bit s, n;
    role = RoleSpace;
    slot = 3'd0;
    s = sp(b);
    n = nmc(b);
    ev = EvNone;
    if (err == ErrOk) begin
      case (pm)
        PmOut:
          if (b == ChLt) begin
            role = RolePunct; pm = PmLt; cidx = 0; acount = 0; closing = 0;
          end else if (s) role = RoleSpace;
          else if (depth > 0) role = RoleText;
          else raise(ErrSyntax);
        PmLt:
          if (b == ChBang) begin role = RolePunct; pm = PmCmtD1; end
          else if (b == ChQuest) begin role = RolePunct; pm = PmPi; end
          else if (b == ChSlash) begin role = RolePunct; closing = 1; pm = PmTagPre; end
          else if (s) pm = PmTagPre;
          else if (n) begin role = RoleTag; pm = PmName; name_char(b); end
          else raise(ErrSyntax);
        PmCmtD1:
          if (b == ChDash) begin role = RolePunct; pm = PmCmtD2; end
          else raise(ErrSyntax);
        PmCmtD2:
          if (b == ChDash) begin role = RolePunct; pm = PmCmt; end
          else raise(ErrSyntax);
        PmCmt: begin
          role = RoleCmt;
          if (b == ChDash) pm = PmCmtE1;
        end
        PmCmtE1: begin
          role = RoleCmt;
          pm = (b == ChDash) ? PmCmtE2 : PmCmt;
        end
        PmCmtE2:
          if (b == ChGt) begin role = RolePunct; pm = PmOut; end
          else begin
            role = RoleCmt;
            if (b != ChDash) pm = PmCmt;
          end
        PmPi:
          if (b == ChQuest) begin role = RolePunct; pm = PmPiQ; end
          else role = RoleCmt;
        PmPiQ:
          if (b == ChGt) begin role = RolePunct; pm = PmOut; end
          else raise(ErrSyntax);
        PmTagPre:
          if (s) role = RoleSpace;
          else if (n) begin role = RoleTag; pm = PmName; name_char(b); end
          else raise(ErrSyntax);
        PmName:
          if (n) begin role = RoleTag; name_char(b); end
          else if (s) begin
            close_name();
            pm = closing ? PmEndWs : PmAttrWait;
          end else if (b == ChGt) begin
            role = RolePunct; close_name();
            if (closing) close_elem(); else open_elem();
          end else if (b == ChSlash && !closing) begin
            role = RolePunct; close_name(); pm = PmEmptyGt;
          end else raise(ErrSyntax);
        PmEndWs:
          if (s) role = RoleSpace;
          else if (b == ChGt) begin role = RolePunct; close_elem(); end
          else raise(ErrSyntax);
        PmAttrWait:
          if (s) role = RoleSpace;
          else if (b == ChGt) begin role = RolePunct; open_elem(); end
          else if (b == ChSlash) begin role = RolePunct; pm = PmEmptyGt; end
          else if (n) begin
            if (acount >= ATTRS_MAX) raise(ErrAttrs);
            else begin
              role = RoleAName; slot = acount[2:0]; cidx = 1; pm = PmAName;
            end
          end else raise(ErrSyntax);
        PmAName: begin
          slot = acount[2:0];
          if (n) begin
            if (cidx >= NAME_MAX) raise(ErrNameLen);
            else begin role = RoleAName; cidx++; end
          end else if (s) pm = PmAEq;
          else if (b == ChEq) begin role = RolePunct; pm = PmAvq; end
          else raise(ErrSyntax);
        end
        PmAEq: begin
          slot = acount[2:0];
          if (s) role = RoleSpace;
          else if (b == ChEq) begin role = RolePunct; pm = PmAvq; end
          else raise(ErrSyntax);
        end
        PmAvq: begin
          slot = acount[2:0];
          if (s) role = RoleSpace;
          else if (b == ChDquot || b == ChSquot) begin
            role = RolePunct; quote = b; pm = PmAval;
          end else raise(ErrSyntax);
        end
        PmAval: begin
          slot = acount[2:0];
          if (b == quote) begin role = RolePunct; acount++; pm = PmAttrWait; end
          else role = RoleAVal;
        end
        PmEmptyGt:
          if (b == ChGt) begin role = RolePunct; ev = EvEmpty; pm = PmOut; end
          else raise(ErrSyntax);
        default: raise(ErrSyntax);
      endcase
      if (err != ErrOk) begin
        role = RoleSpace; slot = 3'd0; ev = EvNone;
      end
    end
    if (err == ErrOk && fin && (pm != PmOut || depth != 0)) raise(ErrTrunc);
    w = '{byte_out: b, role: role, event_res: ev, attr_slot: slot,
          nest_depth: depth[4:0], error_code: err};
  endtask

  // stimulus helpers
  task automatic put(logic [7:0] b, bit fin = 1'b0);
    byte_queue.push_back({fin, b});
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  function automatic logic [7:0] rand_name_ch();
    case ($urandom_range(0, 4))
      0: return 8'($urandom_range("a", "z"));
      1: return 8'($urandom_range("A", "Z"));
      2: return 8'($urandom_range("0", "9"));
      3: return ChUnder;
      default: return ChDot;
    endcase
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(0, 2))
      0: return 8'h20;
      1: return 8'($urandom_range(9, 13));
      default: return 8'h20;
    endcase
  endfunction

  // a well-formed fragment with random content; tags keep a local name stack
  task automatic put_doc(int budget);
    string open_names [$];
    string nm;
    int len, k;
    logic [7:0] q;
    logic [7:0] v;
    while (budget > 0) begin
      k = $urandom_range(0, 9);
      if (k < 3 && open_names.size() < DEPTH_MAX - 1) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, NAME_MAX)
                                           : $urandom_range(1, 5);
        nm = "";
        for (int i = 0; i < len; i++) nm = {nm, string'(rand_name_ch())};
        put(ChLt); put_str(nm);
        repeat ($urandom_range(0, 3)) begin
          put(rand_space());
          repeat ($urandom_range(1, 4)) put(rand_name_ch());
          if ($urandom_range(0, 1)) put(rand_space());
          put(ChEq);
          q = $urandom_range(0, 1) ? ChDquot : ChSquot;
          put(q);
          repeat ($urandom_range(0, 5)) begin
            v = 8'($urandom_range(32, 126));
            put(v == q ? 8'h41 : v);
          end
          put(q);
        end
        if ($urandom_range(0, 3) == 0) begin
          put(ChSlash); put(ChGt);
        end else begin
          put(ChGt); open_names.push_back(nm);
        end
        budget -= len + 2;
      end else if (k < 5 && open_names.size() > 0) begin
        put(ChLt); put(ChSlash); put_str(open_names.pop_back());
        if ($urandom_range(0, 2) == 0) put(rand_space());
        put(ChGt);
        budget -= 4;
      end else if (k == 5) begin
        put_str("<!--");
        repeat ($urandom_range(0, 6)) begin
          v = 8'($urandom_range(0, 255));
          put($urandom_range(0, 3) == 0 ? ChDash : (v == ChGt ? 8'h41 : v));
        end
        put_str("-->");
        budget -= 8;
      end else if (k == 6) begin
        put_str("<?");
        repeat ($urandom_range(0, 5)) put(8'($urandom_range(64, 126)));
        put_str("?>");
        budget -= 5;
      end else if (open_names.size() > 0) begin
        repeat ($urandom_range(1, 4)) put($urandom_range(0, 1) ? rand_space()
                                          : 8'($urandom_range(128, 255)));
        budget -= 2;
      end else begin
        put(rand_space());
        budget--;
      end
    end
    while (open_names.size() > 0) begin
      put(ChLt); put(ChSlash); put_str(open_names.pop_back()); put(ChGt);
    end
  endtask

  // remember whether the offered byte was taken at the last rising edge
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (in_valid_i) void'(byte_queue.pop_front());
      if (byte_queue.size() > 0 && $urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b1;
        byte_in_i  <= byte_queue[0][7:0];
        doc_end_i  <= byte_queue[0][8];
      end else begin
        in_valid_i <= 1'b0;
        byte_in_i  <= 8'($urandom);
        doc_end_i  <= 1'($urandom);
      end
    end
  end

  // receiver stall: mostly short gaps, sometimes long, plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else if ($urandom_range(0, 99) < 3) out_stall_i <= 1'b1;
    else if (out_stall_i && $urandom_range(0, 9) != 0 && $urandom_range(0, 9) < 5)
      out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(0, 4) == 0);
  end

  initial begin
    wait (cycles == 1000);
    hold_off = 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // accepted bytes feed the predictor; accepted words are checked
  always @(posedge clk_i) begin
    tok_word_t w, got;
    cycles <= cycles + 1;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      tokenize(byte_in_i, doc_end_i, w);
      expected_words.push_back(w);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{byte_out_o, role_o, event_res_o, attr_slot_o, nest_depth_o, error_code_o};
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        w = expected_words.pop_front();
        if (got !== w) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch byte %h: exp role %0d ev %0d slot %0d depth %0d err %0d,",
                      " got byte %h role %0d ev %0d slot %0d depth %0d err %0d"},
                     w.byte_out, w.role, w.event_res, w.attr_slot, w.nest_depth,
                     w.error_code, got.byte_out, got.role, got.event_res,
                     got.attr_slot, got.nest_depth, got.error_code);
        end
      end
    end
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    pm = PmOut; depth = 0; cidx = 0; acount = 0; closing = 0; quote = 8'h00;
    err = ErrOk;
    // directed: header, comment with extra dashes, tags, attributes, text, empty tag
    put_str("<?x?>"); put_str("<!-- a--b --->");
    put_str("< A_.z9 k='v' m = \"\xff\"><b/>t\x80<z/></A_.z9 >");
    put(8'h0D, 1'b1);
    // random well-formed documents
    while (byte_queue.size() < 1750) begin
      put_doc($urandom_range(10, 80));
      put(8'h0A, 1'b1);
    end
    // broken tail: depth overflow, too many attributes, unmatched end tag, truncation, long name, noise
    case ($urandom_range(0, 4))
      0: repeat (DEPTH_MAX + 1) put_str("<a>");
      1: begin
        put_str("<a");
        repeat (ATTRS_MAX + 1) put_str(" q=''");
      end
      2: begin put_str("<a><b></a>"); end
      3: begin put_str("<a>"); put(8'h20, 1'b1); end
      default: put_str("<aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa>");
    endcase
    repeat (100) put(8'($urandom), 1'($urandom));
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (byte_queue.size() == 0 && !in_valid_i);
    wait (expected_words.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
